// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the RMSD accumulator.
// Included by crmsd_front.sv and crmsd_back.sv; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property does not hold");

// cond must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- sv/crmsd_pkg.sv -----
// Package of the coordinate RMSD accumulator: widths, codes, run record type.
// No dependencies; used by every other file of the block but assert_macros.svh.
`default_nettype none

package crmsd_pkg;

    // field widths
    localparam int COORD_W = 25;
    localparam int RMS_W   = 26;
    localparam int CNT_W   = 13;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = 64;

    // derived arithmetic widths
    localparam int MAG_W   = COORD_W;          // |difference| of two coordinates
    localparam int SQ_W    = 2 * MAG_W;        // one squared difference
    localparam int SQS_W   = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W  = SUM_W / 2;
    localparam int SREM_W  = ROOT_W + 3;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int DIV_LAST  = SUM_W - 1;
    localparam int SQRT_LAST = ROOT_W - 1;

    // gap mark in query x: 10000 angstrom in thousandths
    localparam logic signed [COORD_W-1:0] GAP_MARK = 25'sd10000000;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG  = 2'd2;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // summary of one finished run
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             too_long;
    } t_run;

endpackage

`default_nettype wire

// ----- sv/crmsd_ifs.sv -----
// Valid/ready channel interfaces for the coordinate pair input and the result output.
// Depends on crmsd_pkg for field widths.
`default_nettype none

interface crmsd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [crmsd_pkg::COORD_W-1:0]    query_x;
    logic signed [crmsd_pkg::COORD_W-1:0]    query_y;
    logic signed [crmsd_pkg::COORD_W-1:0]    query_z;
    logic signed [crmsd_pkg::COORD_W-1:0]    ref_x;
    logic signed [crmsd_pkg::COORD_W-1:0]    ref_y;
    logic signed [crmsd_pkg::COORD_W-1:0]    ref_z;
    logic                                    last_pair;

    modport source (output valid, query_x, query_y, query_z, ref_x, ref_y, ref_z,
                    last_pair, input ready);
    modport sink   (input valid, query_x, query_y, query_z, ref_x, ref_y, ref_z,
                    last_pair, output ready);
endinterface

interface crmsd_out_if;
    logic                              valid;
    logic                              ready;
    logic [crmsd_pkg::RMS_W-1:0]       rms_deviation;
    logic [crmsd_pkg::CNT_W-1:0]       pairs_used;
    logic [crmsd_pkg::STAT_W-1:0]      status;

    modport source (output valid, rms_deviation, pairs_used, status, input ready);
    modport sink   (input valid, rms_deviation, pairs_used, status, output ready);
endinterface

`default_nettype wire

// ----- sv/crmsd_front.sv -----
// Front part: accepts coordinate pairs, drops gaps, squares and accumulates.
// Depends on crmsd_pkg, crmsd_ifs.sv and assert_macros.svh; pushes run records.
`default_nettype none
`include "assert_macros.svh"

module crmsd_front #(
    parameter int MAX_PAIRS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    crmsd_in_if.sink          i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output crmsd_pkg::t_run   o_rec
);
    import crmsd_pkg::*;

    // pipeline advances unless a finished run waits on a full queue
    logic w_adv;
    logic w_acc;
    logic w_gap;
    logic w_at_max;
    logic w_take;
    logic [CNT_W-1:0] w_cnt_nx;
    logic w_long_nx;

    // stage 1: magnitudes of differences
    logic signed [COORD_W:0] w_dx, w_dy, w_dz;
    logic [MAG_W-1:0] w_ax, w_ay, w_az;

    logic             r_s1_valid, r_s1_add, r_s1_last, r_s1_long;
    logic [CNT_W-1:0] r_s1_cnt;
    logic [MAG_W-1:0] r_s1_ax, r_s1_ay, r_s1_az;

    // stage 2: squares
    logic             r_s2_valid, r_s2_add, r_s2_last, r_s2_long;
    logic [CNT_W-1:0] r_s2_cnt;
    logic [SQ_W-1:0]  r_s2_sx, r_s2_sy, r_s2_sz;

    // run state
    logic [CNT_W-1:0] r_cnt;
    logic             r_long;
    logic [SUM_W-1:0] r_sum;

    logic [SQS_W-1:0] w_sqs;
    logic [SUM_W:0]   w_sum_ext;
    logic [SUM_W-1:0] w_sum_sat;
    logic [SUM_W-1:0] w_sum_nx;

    assign w_adv      = !(r_s2_valid && r_s2_last && i_q_full);
    assign i_in.ready = w_adv;
    assign w_acc      = i_in.valid && w_adv;

    // classify the incoming pair
    assign w_gap     = (i_in.query_x == GAP_MARK);
    assign w_at_max  = (r_cnt >= CNT_W'(MAX_PAIRS));
    assign w_take    = w_acc && !w_gap && !w_at_max;
    assign w_cnt_nx  = w_take ? r_cnt + 1'b1 : r_cnt;
    assign w_long_nx = r_long || (w_acc && !w_gap && w_at_max);

    // signed differences and their magnitudes
    assign w_dx = {i_in.query_x[COORD_W-1], i_in.query_x} - {i_in.ref_x[COORD_W-1], i_in.ref_x};
    assign w_dy = {i_in.query_y[COORD_W-1], i_in.query_y} - {i_in.ref_y[COORD_W-1], i_in.ref_y};
    assign w_dz = {i_in.query_z[COORD_W-1], i_in.query_z} - {i_in.ref_z[COORD_W-1], i_in.ref_z};
    assign w_ax = w_dx[COORD_W] ? MAG_W'(-w_dx) : w_dx[MAG_W-1:0];
    assign w_ay = w_dy[COORD_W] ? MAG_W'(-w_dy) : w_dy[MAG_W-1:0];
    assign w_az = w_dz[COORD_W] ? MAG_W'(-w_dz) : w_dz[MAG_W-1:0];

    // counter and too-long flag, cleared with the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_long <= 1'b0;
        end else if (w_acc) begin
            if (i_in.last_pair) begin
                r_cnt  <= '0;
                r_long <= 1'b0;
            end else begin
                r_cnt  <= w_cnt_nx;
                r_long <= w_long_nx;
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_add  <= w_take;
            r_s1_last <= i_in.last_pair;
            r_s1_cnt  <= w_cnt_nx;
            r_s1_long <= w_long_nx;
            r_s1_ax   <= w_ax;
            r_s1_ay   <= w_ay;
            r_s1_az   <= w_az;
        end
    end

    // stage 2 registers: three squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_add  <= r_s1_add;
            r_s2_last <= r_s1_last;
            r_s2_cnt  <= r_s1_cnt;
            r_s2_long <= r_s1_long;
            r_s2_sx   <= r_s1_ax * r_s1_ax;
            r_s2_sy   <= r_s1_ay * r_s1_ay;
            r_s2_sz   <= r_s1_az * r_s1_az;
        end
    end

    // accumulate with saturation
    assign w_sqs     = SQS_W'(r_s2_sx) + SQS_W'(r_s2_sy) + SQS_W'(r_s2_sz);
    assign w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(w_sqs);
    assign w_sum_sat = w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0];
    assign w_sum_nx  = r_s2_add ? w_sum_sat : r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (w_adv && r_s2_valid) begin
            r_sum <= r_s2_last ? '0 : w_sum_nx;
        end
    end

    // run record to the queue
    assign o_push         = w_adv && r_s2_valid && r_s2_last;
    assign o_rec.sum      = w_sum_nx;
    assign o_rec.count    = r_s2_cnt;
    assign o_rec.too_long = r_s2_long;

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, o_push && i_q_full)
    `ASSERT_NEVER(a_cnt_max, i_clk, i_rst_n, r_cnt > CNT_W'(MAX_PAIRS))
    `ASSERT_PROP(a_clear_last, i_clk, i_rst_n, (w_acc && i_in.last_pair) |=> (r_cnt == '0 && !r_long))

endmodule

`default_nettype wire

// ----- sv/crmsd_queue.sv -----
// Short queue of finished run records between the front and back parts.
// Depends on crmsd_pkg for the record type and depth.
`default_nettype none

module crmsd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  crmsd_pkg::t_run   i_rec,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output crmsd_pkg::t_run   o_rec
);
    import crmsd_pkg::*;

    t_run            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_fill;
    logic            w_wr, w_rd;

    assign o_full  = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_rec   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/crmsd_back.sv -----
// Back part: divides the run sum by the count, takes the integer square root,
// and holds the result in the output register. Depends on crmsd_pkg, crmsd_ifs.sv.
`default_nettype none
`include "assert_macros.svh"

module crmsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  crmsd_pkg::t_run   i_rec,
    output logic              o_pop,
    crmsd_out_if.source       o_out
);
    import crmsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_SQRT  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_q;       // dividend, then quotient, then shifted radicand
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [ROOT_W-1:0] r_root;
    logic [SREM_W-1:0] r_srem;
    logic [RMS_W-1:0]  r_res;
    logic [CNT_W-1:0]  r_pairs;
    logic [STAT_W-1:0] r_stat;

    logic              r_out_valid;
    logic [RMS_W-1:0]  r_o_rms;
    logic [CNT_W-1:0]  r_o_pairs;
    logic [STAT_W-1:0] r_o_stat;

    logic              w_load;

    // restoring divide step: one quotient bit
    logic [CNT_W:0]    w_rem_sh;
    logic              w_dge;
    // square root step: one root bit from two radicand bits
    logic [SREM_W-1:0] w_srem_sh;
    logic [SREM_W-1:0] w_trial;
    logic              w_sge;
    logic [ROOT_W-1:0] w_root_nx;

    assign w_rem_sh  = {r_rem, r_q[SUM_W-1]};
    assign w_dge     = (w_rem_sh >= {1'b0, r_div});
    assign w_srem_sh = {r_srem[SREM_W-3:0], r_q[SUM_W-1:SUM_W-2]};
    assign w_trial   = SREM_W'({r_root, 2'b01});
    assign w_sge     = (w_srem_sh >= w_trial);
    assign w_root_nx = {r_root[ROOT_W-2:0], w_sge};

    assign o_pop  = (r_state == S_IDLE) && i_q_valid;
    assign w_load = (r_state == S_WRITE) && (!r_out_valid || o_out.ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_step  <= '0;
                        r_state <= (i_rec.count == '0) ? S_WRITE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_LAST)) begin
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SQRT_LAST)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q     <= i_rec.sum;
                r_rem   <= '0;
                r_div   <= i_rec.count;
                r_pairs <= i_rec.count;
                r_res   <= '0;
                if (i_rec.count == '0) begin
                    r_stat <= ST_EMPTY;
                end else begin
                    r_stat <= i_rec.too_long ? ST_LONG : ST_OK;
                end
            end
            S_DIV: begin
                r_rem  <= w_dge ? CNT_W'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[CNT_W-1:0];
                r_q    <= {r_q[SUM_W-2:0], w_dge};
                r_root <= '0;
                r_srem <= '0;
            end
            S_SQRT: begin
                r_srem <= w_sge ? w_srem_sh - w_trial : w_srem_sh;
                r_root <= w_root_nx;
                r_q    <= {r_q[SUM_W-3:0], 2'b00};
                r_res  <= w_root_nx[RMS_W-1:0];
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_rms   <= r_res;
            r_o_pairs <= r_pairs;
            r_o_stat  <= r_stat;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.rms_deviation = r_o_rms;
    assign o_out.pairs_used    = r_o_pairs;
    assign o_out.status        = r_o_stat;

    `ASSERT_PROP(a_rem_below_div, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_rem < r_div))
    `ASSERT_PROP(a_pop_idle, i_clk, i_rst_n, o_pop |=> (r_state != S_IDLE))
    `ASSERT_PROP(a_empty_zero, i_clk, i_rst_n, (r_out_valid && r_o_stat == ST_EMPTY) |-> (r_o_pairs == '0 && r_o_rms == '0))

endmodule

`default_nettype wire

// ----- sv/coordinate_rmsd_accumulator.sv -----
// Coordinate RMSD accumulator. Pairs are taken one per cycle unless input
// stalls: each non-gap pair (query x other than 10000000) goes through a
// square-and-add pipeline (difference magnitudes, squares) into a saturating
// 64-bit sum, counted up to MAX_PAIRS. The item with last_pair set closes the
// run; its summary passes through a two-entry queue to the back part, which
// does a bit-serial divide of the sum by the count and then a bit-serial
// square root; an empty run skips both. The back part handles one run at a
// time; input stalls only when two finished runs already wait and a third one
// ends, so runs longer than the back part's work on one run stream at one pair
// per cycle while results are taken. No clearing pass is needed after reset.
`default_nettype none

module coordinate_rmsd_accumulator #(
    parameter int MAX_PAIRS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crmsd_in_if.sink  i_in,
    crmsd_out_if.source o_out
);
    import crmsd_pkg::*;

    logic w_push, w_full, w_q_valid, w_pop;
    t_run w_rec_in, w_rec_out;

    crmsd_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_rec    (w_rec_in)
    );

    crmsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_rec   (w_rec_out)
    );

    crmsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_rec     (w_rec_out),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
